// File: hw/rtl/i2af_pkg.sv
// Shared types, codes and character constants for the integer to ASCII formatter.
// Used by i2af_bcd, i2af_emit and integer_to_ascii_formatter_core; no dependencies.
package i2af_pkg;

   localparam int POINTER_BITS_DEF = 64;
   localparam int ACTION_W         = 3;
   localparam int VALUE_W          = 64;
   localparam int FWIDTH_W         = 6;
   localparam int CHAR_W           = 8;
   localparam int LEN_W            = 5;
   localparam int BIN_W            = 32;
   localparam int DEC_DIGITS       = 10;
   localparam int BCD_W            = 4 * DEC_DIGITS;

   localparam logic [ACTION_W-1:0] ACT_SDEC = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_UDEC = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_LHEX = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_UHEX = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_PTR  = 3'd4;

   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
   localparam logic [CHAR_W-1:0] CH_UPPER = 8'h41;
   localparam logic [CHAR_W-1:0] CH_LOWER = 8'h61;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [VALUE_W-1:0]  value;
      logic [FWIDTH_W-1:0] field_width;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_out;
      logic              last_char;
      logic [LEN_W-1:0]  printed_length;
   } rsp_type;

   typedef struct packed {
      logic                start;
      logic                neg;
      logic                ptr_prefix;
      logic                upper;
      logic [FWIDTH_W-1:0] field_width;
   } emit_ctl_type;

   typedef enum logic {
      CORE_IDLE,
      CORE_CONVERT
   } core_state_type;

   typedef enum logic [2:0] {
      EMIT_IDLE,
      EMIT_SCAN,
      EMIT_PAD,
      EMIT_PREFIX,
      EMIT_DIGIT
   } emit_state_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] nib, input logic upper);
      logic [CHAR_W-1:0] base;
      base = upper ? CH_UPPER : CH_LOWER;
      if (nib < 4'd10)
         digit_char = CH_ZERO + {4'd0, nib};
      else
         digit_char = base + {4'd0, nib} - 8'd10;
   endfunction

endpackage

// File: hw/rtl/i2af_bcd.sv
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
// Depends on i2af_pkg.
module i2af_bcd (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [i2af_pkg::BIN_W-1:0] bin,
   output logic                       done,
   output logic [i2af_pkg::BCD_W-1:0] bcd
);

   localparam int CNT_W = $clog2(i2af_pkg::BIN_W);

   logic [i2af_pkg::BIN_W-1:0] bin_ff, bin_in;
   logic [i2af_pkg::BCD_W-1:0] bcd_ff, bcd_in, adj;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;

   always_comb begin
      for (int i = 0; i < i2af_pkg::DEC_DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                     : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in  = bin;
         bcd_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         {bcd_in, bin_in} = {adj[i2af_pkg::BCD_W-2:0], bin_ff, 1'b0};
         cnt_in           = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(i2af_pkg::BIN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

// File: hw/rtl/i2af_emit.sv
// Digit shift register with leading-zero scan and character sequencer; drives the result
// channel through an output register. Depends on i2af_pkg.
module i2af_emit #(
   parameter int DIGITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  i2af_pkg::emit_ctl_type     ctl,
   input  logic [4*DIGITS-1:0]        digits,
   output logic                       busy,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output i2af_pkg::rsp_type          rsp_data
);

   localparam int DW = 4 * DIGITS;
   localparam int NW = $clog2(DIGITS + 1);

   i2af_pkg::emit_state_type state_ff, state_in;
   logic [DW-1:0]                 d_ff, d_in;
   logic [NW-1:0]                 ndig_ff, ndig_in;
   logic [1:0]                    pre_ff, pre_in;
   logic                          neg_ff, neg_in;
   logic                          upper_ff, upper_in;
   logic [i2af_pkg::FWIDTH_W-1:0] width_ff, width_in;
   logic [i2af_pkg::FWIDTH_W-1:0] pad_ff, pad_in;
   logic [i2af_pkg::LEN_W-1:0]    len_ff, len_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   i2af_pkg::rsp_type             rsp_ff, rsp_in;

   logic                          slot_free;
   logic [i2af_pkg::LEN_W-1:0]    len_calc;
   logic [3:0]                    top_nib;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign top_nib   = d_ff[DW-1 -: 4];
   assign len_calc  = i2af_pkg::LEN_W'(ndig_ff) + i2af_pkg::LEN_W'(pre_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= i2af_pkg::EMIT_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      d_ff     <= d_in;
      ndig_ff  <= ndig_in;
      pre_ff   <= pre_in;
      neg_ff   <= neg_in;
      upper_ff <= upper_in;
      width_ff <= width_in;
      pad_ff   <= pad_in;
      len_ff   <= len_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      d_in         = d_ff;
      ndig_in      = ndig_ff;
      pre_in       = pre_ff;
      neg_in       = neg_ff;
      upper_in     = upper_ff;
      width_in     = width_ff;
      pad_in       = pad_ff;
      len_in       = len_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         i2af_pkg::EMIT_IDLE: begin
            if (ctl.start) begin
               d_in     = digits;
               ndig_in  = NW'(DIGITS);
               neg_in   = ctl.neg;
               upper_in = ctl.upper;
               width_in = ctl.field_width;
               pre_in   = ctl.neg ? 2'd1 : (ctl.ptr_prefix ? 2'd2 : 2'd0);
               state_in = i2af_pkg::EMIT_SCAN;
            end
         end
         i2af_pkg::EMIT_SCAN: begin
            if (ndig_ff > NW'(1) && top_nib == 4'd0) begin
               d_in    = {d_ff[DW-5:0], 4'd0};
               ndig_in = ndig_ff - 1'b1;
            end else begin
               len_in = len_calc;
               if (width_ff > i2af_pkg::FWIDTH_W'(len_calc)) begin
                  pad_in   = width_ff - i2af_pkg::FWIDTH_W'(len_calc);
                  state_in = i2af_pkg::EMIT_PAD;
               end else if (pre_ff != 2'd0) begin
                  state_in = i2af_pkg::EMIT_PREFIX;
               end else begin
                  state_in = i2af_pkg::EMIT_DIGIT;
               end
            end
         end
         i2af_pkg::EMIT_PAD: begin
            if (slot_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.char_out       = i2af_pkg::CH_SPACE;
               rsp_in.last_char      = 1'b0;
               rsp_in.printed_length = '0;
               pad_in                = pad_ff - 1'b1;
               if (pad_ff == i2af_pkg::FWIDTH_W'(1))
                  state_in = (pre_ff != 2'd0) ? i2af_pkg::EMIT_PREFIX : i2af_pkg::EMIT_DIGIT;
            end
         end
         i2af_pkg::EMIT_PREFIX: begin
            if (slot_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.last_char      = 1'b0;
               rsp_in.printed_length = '0;
               if (neg_ff)
                  rsp_in.char_out = i2af_pkg::CH_MINUS;
               else if (pre_ff == 2'd2)
                  rsp_in.char_out = i2af_pkg::CH_ZERO;
               else
                  rsp_in.char_out = i2af_pkg::CH_X;
               pre_in = pre_ff - 1'b1;
               if (pre_ff == 2'd1)
                  state_in = i2af_pkg::EMIT_DIGIT;
            end
         end
         i2af_pkg::EMIT_DIGIT: begin
            if (slot_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.char_out       = i2af_pkg::digit_char(top_nib, upper_ff);
               rsp_in.last_char      = (ndig_ff == NW'(1));
               rsp_in.printed_length = (ndig_ff == NW'(1)) ? len_ff : '0;
               d_in                  = {d_ff[DW-5:0], 4'd0};
               ndig_in               = ndig_ff - 1'b1;
               if (ndig_ff == NW'(1))
                  state_in = i2af_pkg::EMIT_IDLE;
            end
         end
         default: state_in = i2af_pkg::EMIT_IDLE;
      endcase
   end

   assign busy      = (state_ff != i2af_pkg::EMIT_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: hw/rtl/integer_to_ascii_formatter_core.sv
// Top level of the integer to ASCII formatter: request decode, sign handling and dispatch.
// Depends on i2af_pkg, i2af_bcd and i2af_emit.
//
// Formats one integer per transaction as printf %d, %u, %x, %X or %p would and returns the
// field one character per result transaction, right-justified with spaces to field_width (a
// zero outside signed decimal is printed bare and unpadded); the last character carries
// last_char and the printed length. One transaction is in work at a time. Hex and pointer
// items pass through acceptance, a scan that drops one leading digit per cycle from DIGITS
// digits (DIGITS = 16 at the default pointer width) and the emission of each character in
// turn. Decimal items first pass through the bit-serial BCD converter ahead of the same scan,
// which starts from all DIGITS digits of the zero-extended BCD result. Codes 5 to 7 produce
// no results and leave the input channel free. Output stalls hold the sequencer without loss.
module integer_to_ascii_formatter_core #(
   parameter int POINTER_BITS = i2af_pkg::POINTER_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  i2af_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output i2af_pkg::rsp_type rsp_data
);

   localparam int PTR_DIGITS = (POINTER_BITS + 3) / 4;
   localparam int DIGITS     = (PTR_DIGITS > i2af_pkg::DEC_DIGITS) ? PTR_DIGITS
                                                                   : i2af_pkg::DEC_DIGITS;
   localparam int DW         = 4 * DIGITS;

   i2af_pkg::core_state_type      state_ff, state_in;
   logic                          neg_ff, neg_in;
   logic [i2af_pkg::FWIDTH_W-1:0] width_ff, width_in;

   logic                          accept;
   logic                          emit_busy;
   logic                          bcd_start;
   logic                          bcd_done;
   logic [i2af_pkg::BCD_W-1:0]    bcd;
   logic [i2af_pkg::BIN_W-1:0]    low;
   logic [i2af_pkg::BIN_W-1:0]    mag;
   logic [POINTER_BITS-1:0]       ptr;
   logic                          low_zero;
   logic                          ptr_zero;
   i2af_pkg::emit_ctl_type        ctl;
   logic [DW-1:0]                 digits;

   assign req_stall = (state_ff != i2af_pkg::CORE_IDLE) || emit_busy;
   assign accept    = req_valid && !req_stall;
   assign low       = req_data.value[i2af_pkg::BIN_W-1:0];
   assign ptr       = req_data.value[POINTER_BITS-1:0];
   assign low_zero  = (low == '0);
   assign ptr_zero  = (ptr == '0);
   assign mag       = (req_data.action == i2af_pkg::ACT_SDEC && low[i2af_pkg::BIN_W-1])
                      ? (~low + 1'b1) : low;

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= i2af_pkg::CORE_IDLE;
      else
         state_ff <= state_in;
      neg_ff   <= neg_in;
      width_ff <= width_in;
   end

   always_comb begin
      state_in        = state_ff;
      neg_in          = neg_ff;
      width_in        = width_ff;
      bcd_start       = 1'b0;
      ctl.start       = 1'b0;
      ctl.neg         = 1'b0;
      ctl.ptr_prefix  = 1'b0;
      ctl.upper       = 1'b0;
      ctl.field_width = '0;
      digits          = DW'(low);
      unique case (state_ff)
         i2af_pkg::CORE_IDLE: begin
            if (accept) begin
               unique case (req_data.action) inside
                  i2af_pkg::ACT_SDEC, i2af_pkg::ACT_UDEC: begin
                     bcd_start = 1'b1;
                     neg_in    = (req_data.action == i2af_pkg::ACT_SDEC)
                                 && low[i2af_pkg::BIN_W-1];
                     width_in  = (req_data.action == i2af_pkg::ACT_UDEC && low_zero)
                                 ? '0 : req_data.field_width;
                     state_in  = i2af_pkg::CORE_CONVERT;
                  end
                  i2af_pkg::ACT_LHEX, i2af_pkg::ACT_UHEX: begin
                     ctl.start       = 1'b1;
                     ctl.upper       = (req_data.action == i2af_pkg::ACT_UHEX);
                     ctl.field_width = low_zero ? '0 : req_data.field_width;
                     digits          = DW'(low);
                  end
                  i2af_pkg::ACT_PTR: begin
                     ctl.start       = 1'b1;
                     ctl.ptr_prefix  = !ptr_zero;
                     ctl.field_width = ptr_zero ? '0 : req_data.field_width;
                     digits          = DW'(ptr);
                  end
                  default: ;
               endcase
            end
         end
         i2af_pkg::CORE_CONVERT: begin
            if (bcd_done) begin
               ctl.start       = 1'b1;
               ctl.neg         = neg_ff;
               ctl.field_width = width_ff;
               digits          = DW'(bcd);
               state_in        = i2af_pkg::CORE_IDLE;
            end
         end
         default: state_in = i2af_pkg::CORE_IDLE;
      endcase
   end

   i2af_bcd u_bcd (
      .clock (clock),
      .reset (reset),
      .start (bcd_start),
      .bin   (mag),
      .done  (bcd_done),
      .bcd   (bcd)
   );

   i2af_emit #(
      .DIGITS (DIGITS)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .digits    (digits),
      .busy      (emit_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: test/i2af_field_checker.sv
`timescale 1ns / 1ps
// Checker for integer_to_ascii_formatter_core: watches both channels, predicts each field.
// Depends on i2af_pkg; reports its mismatch count and the number of characters still due.
module i2af_field_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  i2af_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  i2af_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                chars_pending
);

   localparam int PTR_BITS = i2af_pkg::POINTER_BITS_DEF;
   localparam logic [i2af_pkg::VALUE_W-1:0] PTR_MASK =
      (PTR_BITS >= i2af_pkg::VALUE_W) ? {i2af_pkg::VALUE_W{1'b1}}
                                      : ((64'd1 << PTR_BITS) - 64'd1);
   localparam logic [127:0] LOWER_SET = "0123456789abcdef";
   localparam logic [127:0] UPPER_SET = "0123456789ABCDEF";

   i2af_pkg::rsp_type chars_due[$];
   i2af_pkg::rsp_type due;
   int                mismatches;

   function automatic void format_field(input i2af_pkg::req_type item);
      logic [i2af_pkg::CHAR_W-1:0] text[$];
      logic [63:0]                 mag;
      logic [63:0]                 base;
      logic [31:0]                 low;
      logic                        upper;
      logic                        neg;
      logic                        prefix;
      logic                        emits;
      int                          nib;
      int                          fw;
      int                          pad;
      int                          total;
      i2af_pkg::rsp_type           ch;
      low    = item.value[31:0];
      mag    = {32'd0, low};
      fw     = item.field_width;
      base   = 64'd16;
      upper  = 1'b0;
      neg    = 1'b0;
      prefix = 1'b0;
      emits  = 1'b1;
      case (item.action)
         i2af_pkg::ACT_SDEC: begin
            base = 64'd10;
            if (low[31]) begin
               neg = 1'b1;
               mag = {32'd0, 32'd0 - low};
            end
         end
         i2af_pkg::ACT_UDEC: base = 64'd10;
         i2af_pkg::ACT_LHEX: upper = 1'b0;
         i2af_pkg::ACT_UHEX: upper = 1'b1;
         i2af_pkg::ACT_PTR: begin
            mag    = item.value & PTR_MASK;
            prefix = 1'b1;
         end
         default: emits = 1'b0;
      endcase
      if (!emits)
         return;
      // a zero prints as a bare unpadded digit, except in signed decimal
      if (mag == 64'd0 && item.action != i2af_pkg::ACT_SDEC) begin
         fw     = 0;
         prefix = 1'b0;
      end
      do begin
         nib = int'(mag % base);
         text.push_front(upper ? UPPER_SET[(15 - nib) * 8 +: 8] : LOWER_SET[(15 - nib) * 8 +: 8]);
         mag = mag / base;
      end while (mag != 64'd0);
      if (prefix) begin
         text.push_front(i2af_pkg::CH_X);
         text.push_front(i2af_pkg::CH_ZERO);
      end
      if (neg)
         text.push_front(i2af_pkg::CH_MINUS);
      pad   = (fw > text.size()) ? fw - text.size() : 0;
      total = pad + text.size();
      for (int k = 0; k < total; k++) begin
         ch.char_out       = (k < pad) ? i2af_pkg::CH_SPACE : text[k - pad];
         ch.last_char      = (k == total - 1);
         ch.printed_length = ch.last_char ? i2af_pkg::LEN_W'(text.size()) : '0;
         chars_due.push_back(ch);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         chars_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (chars_due.size() == 0) begin
               $error("unexpected transaction: char_out %h last_char %b printed_length %0d",
                      rsp_data.char_out, rsp_data.last_char, rsp_data.printed_length);
               mismatches++;
            end else begin
               due = chars_due.pop_front();
               if (rsp_data.char_out !== due.char_out) begin
                  $error("char_out: expected %h, got %h", due.char_out, rsp_data.char_out);
                  mismatches++;
               end
               if (rsp_data.last_char !== due.last_char) begin
                  $error("last_char: expected %b, got %b", due.last_char, rsp_data.last_char);
                  mismatches++;
               end
               if (rsp_data.printed_length !== due.printed_length) begin
                  $error("printed_length: expected %0d, got %0d",
                         due.printed_length, rsp_data.printed_length);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall)
            format_field(req_data);
      end
      fail_count    <= mismatches;
      chars_pending <= chars_due.size();
   end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Testbench top for integer_to_ascii_formatter_core: clock, reset, stimulus and verdict.
// Depends on i2af_pkg, the core and i2af_field_checker, which does all prediction and comparison.
module tb;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 150;
   localparam int RANDOM_ITEMS = 107;
   localparam logic [i2af_pkg::ACTION_W-1:0] ACT_UNUSED_FIRST = i2af_pkg::ACT_PTR + 3'd1;
   localparam logic [i2af_pkg::ACTION_W-1:0] ACT_UNUSED_LAST  = 3'd7;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   i2af_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   i2af_pkg::rsp_type rsp_data;
   logic              pace_stall;
   logic              long_hold;
   int                fail_count;
   int                chars_pending;
   int                sent;
   int                taken;

   assign rsp_stall = pace_stall | long_hold;

   integer_to_ascii_formatter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   i2af_field_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .chars_pending (chars_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic i2af_pkg::req_type make_req(
      input logic [i2af_pkg::ACTION_W-1:0] action,
      input logic [i2af_pkg::VALUE_W-1:0]  value,
      input int                            fw);
      i2af_pkg::req_type item;
      item.action      = action;
      item.value       = value;
      item.field_width = i2af_pkg::FWIDTH_W'(fw);
      return item;
   endfunction

   function automatic i2af_pkg::req_type random_item();
      i2af_pkg::req_type item;
      logic [63:0]       v;
      int                r;
      if ($urandom_range(0, 9) == 0)
         item.action = i2af_pkg::ACTION_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
      else
         item.action = i2af_pkg::ACTION_W'($urandom_range(i2af_pkg::ACT_SDEC,
                                                          i2af_pkg::ACT_PTR));
      case ($urandom_range(0, 5))
         0: v = $urandom_range(0, 1) ? 64'd0 : {$urandom, 32'd0};
         1: v = 64'($urandom_range(0, 99));
         2: v = {$urandom, $urandom};
         3: v = {$urandom, 32'd0 - 32'($urandom_range(1, 20))};
         4: v = {$urandom, $urandom} >> $urandom_range(0, 63);
         default: v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
      endcase
      item.value = v;
      r = $urandom_range(0, 9);
      if (r < 7)
         item.field_width = i2af_pkg::FWIDTH_W'($urandom_range(0, 12));
      else if (r < 9)
         item.field_width = i2af_pkg::FWIDTH_W'($urandom_range(13, 62));
      else
         item.field_width = {i2af_pkg::FWIDTH_W{1'b1}};
      return item;
   endfunction

   task automatic send_item(input i2af_pkg::req_type item);
      int gap;
      gap = (sent % 32 < 10) ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   initial begin
      i2af_pkg::req_type plan[$];
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      pace_stall = 1'b0;
      long_hold  = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      plan.push_back(make_req(i2af_pkg::ACT_SDEC, 64'd0, 0));
      plan.push_back(make_req(i2af_pkg::ACT_SDEC, 64'd0, 5));
      plan.push_back(make_req(i2af_pkg::ACT_SDEC, 64'h0000_0000_7fff_ffff, 0));
      plan.push_back(make_req(i2af_pkg::ACT_SDEC, 64'h0000_0000_8000_0000, 63));
      plan.push_back(make_req(i2af_pkg::ACT_SDEC, 64'hffff_ffff_ffff_ffff, 3));
      plan.push_back(make_req(i2af_pkg::ACT_SDEC, 64'hffff_ffff_0000_0005, 1));
      plan.push_back(make_req(i2af_pkg::ACT_UDEC, 64'd0, 10));
      plan.push_back(make_req(i2af_pkg::ACT_UDEC, 64'h0000_0000_ffff_ffff, 12));
      plan.push_back(make_req(i2af_pkg::ACT_UDEC, 64'd1, 63));
      plan.push_back(make_req(i2af_pkg::ACT_UDEC, 64'hdead_beef_0000_0000, 8));
      plan.push_back(make_req(i2af_pkg::ACT_LHEX, 64'd0, 4));
      plan.push_back(make_req(i2af_pkg::ACT_LHEX, 64'h0000_0000_ffff_ffff, 0));
      plan.push_back(make_req(i2af_pkg::ACT_LHEX, 64'h1234_5678_abcd_ef01, 10));
      plan.push_back(make_req(i2af_pkg::ACT_UHEX, 64'h0000_0000_89ab_cdef, 9));
      plan.push_back(make_req(i2af_pkg::ACT_UHEX, 64'd0, 63));
      plan.push_back(make_req(i2af_pkg::ACT_PTR, 64'd0, 20));
      plan.push_back(make_req(i2af_pkg::ACT_PTR, 64'hffff_ffff_ffff_ffff, 0));
      plan.push_back(make_req(i2af_pkg::ACT_PTR, 64'd1, 63));
      plan.push_back(make_req(i2af_pkg::ACT_PTR, 64'h0123_4567_89ab_cdef, 5));
      plan.push_back(make_req(i2af_pkg::ACT_PTR, 64'h0000_0001_0000_0000, 19));
      plan.push_back(make_req(ACT_UNUSED_FIRST, 64'd42, 7));
      plan.push_back(make_req(ACT_UNUSED_FIRST + 3'd1, 64'hffff_ffff_ffff_ffff, 63));
      plan.push_back(make_req(ACT_UNUSED_LAST, 64'd0, 0));
      for (int i = 0; i < RANDOM_ITEMS; i++)
         plan.push_back(random_item());

      foreach (plan[i])
         send_item(plan[i]);
      req_valid <= 1'b0;

      @(posedge clock);
      while (chars_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("** integer_to_ascii_formatter_core: PASSED **");
      else
         $display("** integer_to_ascii_formatter_core: FAILED **");
      $finish;
   end

   initial begin
      int hold;
      wait (reset == 1'b0);
      forever begin
         hold = ((taken / 40) % 3 == 1) ? 0 : $urandom_range(0, 6);
         if (hold != 0) begin
            pace_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         pace_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
         taken++;
      end
   end

   // hold off the result channel long enough for the input to back up
   initial begin
      wait (reset == 1'b0);
      repeat (300) @(posedge clock);
      long_hold <= 1'b1;
      repeat (500) @(posedge clock);
      long_hold <= 1'b0;
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("** integer_to_ascii_formatter_core: FAILED **");
      $finish;
   end

endmodule
